// File: hw/rtl/b2da_pkg.sv
// shared types and constants for the binary to decimal ascii converter
package b2da_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned EXT_W   = 64;
  localparam int unsigned CHAR_W  = 6;
  localparam int unsigned DIGIT_W = 4;

  localparam logic [CHAR_W-1:0]  ASCII_ZERO = 6'd48;
  localparam logic [DIGIT_W-1:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [DIGIT_W-1:0] BCD_ADJ_ADD = 4'd3;

  typedef enum logic [1:0] {
    FRONT_IDLE,
    FRONT_CONV,
    FRONT_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    BACK_IDLE,
    BACK_SKIP,
    BACK_EMIT
  } back_state_e;

endpackage

// File: hw/rtl/binary_to_decimal_ascii_top.sv
// top level of the binary to decimal ascii converter
//
//  channel  handshake           payload                        dir
//  input    push / full         value_i[31:0]                  in
//  result   empty / pop         digit_char_o[5:0], last_digit_o out
//
// the front takes an item, then runs VALUE_BITS shift-and-add-3 steps and
// one queue write, and takes no new item until that write is done; the write
// waits while the queue is full. the back loads a word, drops leading zeros
// and sends one digit a cycle while pop keeps up.
// a two-entry queue lets the front convert while the back is stalled by pop.
// rst_ni clears both state machines, the queue state and the result valid bit.
module binary_to_decimal_ascii_top import b2da_pkg::*; #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [VALUE_W-1:0] value_i,
  output logic               empty,
  input  logic               pop,
  output logic [CHAR_W-1:0]  digit_char_o,
  output logic               last_digit_o
);

  // decimal digits of 2**VALUE_BITS - 1
  localparam int unsigned NDIG  = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int unsigned BCD_W = NDIG * DIGIT_W;

  logic             q_push, q_full, q_pop, q_empty;
  logic [BCD_W-1:0] q_wdata, q_rdata;

  b2da_front #(
    .VALUE_BITS(VALUE_BITS),
    .NDIG      (NDIG)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .value_i  (value_i),
    .q_push_o (q_push),
    .q_full_i (q_full),
    .q_wdata_o(q_wdata)
  );

  b2da_fifo #(
    .WIDTH(BCD_W)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .wdata_i(q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .rdata_o(q_rdata),
    .empty_o(q_empty)
  );

  b2da_back #(
    .NDIG(NDIG)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_pop_o     (q_pop),
    .q_empty_i   (q_empty),
    .q_rdata_i   (q_rdata),
    .empty       (empty),
    .pop         (pop),
    .digit_char_o(digit_char_o),
    .last_digit_o(last_digit_o)
  );

endmodule

// File: hw/rtl/b2da_front.sv
// front end: accepts a value and converts it to packed bcd by shift-and-add-3
module b2da_front import b2da_pkg::*; #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned NDIG       = 10
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push,
  output logic                    full,
  input  logic [VALUE_W-1:0]      value_i,
  output logic                    q_push_o,
  input  logic                    q_full_i,
  output logic [NDIG*DIGIT_W-1:0] q_wdata_o
);

  localparam int unsigned BCD_W = NDIG * DIGIT_W;
  localparam int unsigned CNT_W = $clog2(VALUE_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_BITS - 1);

  front_state_e state_q, state_d;
  logic [VALUE_BITS-1:0] bin_q, bin_d;
  logic [BCD_W-1:0]      bcd_q, bcd_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [EXT_W-1:0]      value_ext;
  logic [BCD_W-1:0]      bcd_adj;
  logic [BCD_W-1:0]      bcd_shift;

  // bits above VALUE_BITS are dropped, missing ones are zero
  assign value_ext = EXT_W'(value_i);

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_q[i*DIGIT_W +: DIGIT_W] >= BCD_ADJ_MIN) begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W] + BCD_ADJ_ADD;
      end else begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  assign bcd_shift = {bcd_adj[BCD_W-2:0], bin_q[VALUE_BITS-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FRONT_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
    cnt_q <= cnt_d;
  end

  always_comb begin
    state_d  = state_q;
    bin_d    = bin_q;
    bcd_d    = bcd_q;
    cnt_d    = cnt_q;
    q_push_o = 1'b0;
    unique case (state_q)
      FRONT_IDLE: begin
        if (push) begin
          bin_d   = value_ext[VALUE_BITS-1:0];
          bcd_d   = '0;
          cnt_d   = '0;
          state_d = FRONT_CONV;
        end
      end
      FRONT_CONV: begin
        bcd_d = bcd_shift;
        bin_d = bin_q << 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          state_d = FRONT_PUSH;
        end
      end
      FRONT_PUSH: begin
        if (!q_full_i) begin
          q_push_o = 1'b1;
          state_d  = FRONT_IDLE;
        end
      end
      default: begin
        state_d = FRONT_IDLE;
      end
    endcase
  end

  assign full      = (state_q != FRONT_IDLE);
  assign q_wdata_o = bcd_q;

endmodule

// File: hw/rtl/b2da_fifo.sv
// two-entry queue of converted bcd words between front and back
module b2da_fifo #(
  parameter int unsigned WIDTH = 40
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  assign rdata_o = mem_q[rptr_q];
  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);

endmodule

// File: hw/rtl/b2da_back.sv
// back end: skips leading zeros and sends one ascii digit per transfer
module b2da_back import b2da_pkg::*; #(
  parameter int unsigned NDIG = 10
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  output logic                    q_pop_o,
  input  logic                    q_empty_i,
  input  logic [NDIG*DIGIT_W-1:0] q_rdata_i,
  output logic                    empty,
  input  logic                    pop,
  output logic [CHAR_W-1:0]       digit_char_o,
  output logic                    last_digit_o
);

  localparam int unsigned BCD_W = NDIG * DIGIT_W;
  localparam int unsigned REM_W = $clog2(NDIG + 1);
  localparam logic [REM_W-1:0] REM_FULL = REM_W'(NDIG);
  localparam logic [REM_W-1:0] REM_ONE  = REM_W'(1);

  back_state_e state_q, state_d;
  logic [BCD_W-1:0]   bcd_q, bcd_d;
  logic [REM_W-1:0]   rem_q, rem_d;
  logic               valid_q, valid_d;
  logic [CHAR_W-1:0]  char_q, char_d;
  logic               last_q, last_d;
  logic [DIGIT_W-1:0] top_digit;
  logic               out_free;

  assign top_digit = bcd_q[BCD_W-1 -: DIGIT_W];
  assign out_free  = !valid_q || pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BACK_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q  <= bcd_d;
    rem_q  <= rem_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  always_comb begin
    state_d = state_q;
    bcd_d   = bcd_q;
    rem_d   = rem_q;
    char_d  = char_q;
    last_d  = last_q;
    valid_d = valid_q && !pop;
    q_pop_o = 1'b0;
    unique case (state_q)
      BACK_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          bcd_d   = q_rdata_i;
          rem_d   = REM_FULL;
          state_d = BACK_SKIP;
        end
      end
      BACK_SKIP: begin
        // the last digit is always sent, so a zero value gives one '0'
        if (top_digit == '0 && rem_q != REM_ONE) begin
          bcd_d = bcd_q << DIGIT_W;
          rem_d = rem_q - 1'b1;
        end else begin
          state_d = BACK_EMIT;
        end
      end
      BACK_EMIT: begin
        if (out_free) begin
          valid_d = 1'b1;
          char_d  = ASCII_ZERO + CHAR_W'(top_digit);
          last_d  = (rem_q == REM_ONE);
          bcd_d   = bcd_q << DIGIT_W;
          rem_d   = rem_q - 1'b1;
          if (rem_q == REM_ONE) begin
            state_d = BACK_IDLE;
          end
        end
      end
      default: begin
        state_d = BACK_IDLE;
      end
    endcase
  end

  assign empty        = !valid_q;
  assign digit_char_o = char_q;
  assign last_digit_o = last_q;

endmodule

// File: hw/rtl/b2da_checker.sv
// port-level checks for the binary to decimal ascii converter
module b2da_checker import b2da_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               push,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input logic [CHAR_W-1:0]  digit_char_o,
  input logic               last_digit_o
);

  // a waiting result holds until its transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(digit_char_o) && $stable(last_digit_o)))
    else $error("result changed before its transfer");

  // every result is a decimal digit character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (digit_char_o >= ASCII_ZERO && digit_char_o <= ASCII_ZERO + 6'd9))
    else $error("result is not a decimal digit");

  // the converter is busy right after taking an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |=> full)
    else $error("input side free right after a transfer");

  // both sides are idle when reset is released
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> (empty && !full))
    else $error("ports not idle after reset");

endmodule

bind binary_to_decimal_ascii_top b2da_checker u_b2da_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .push        (push),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .digit_char_o(digit_char_o),
  .last_digit_o(last_digit_o)
);

// File: tb/binary_to_decimal_ascii_top_test.sv
// self-checking testbench for the binary to decimal ascii converter
module binary_to_decimal_ascii_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import b2da_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned TAIL_CYCLES = 60;
  localparam int unsigned RANDOM_ITEMS = 130;

  // expected digit stream for every accepted value, oldest first
  class digit_scoreboard;
    logic [CHAR_W-1:0] char_q[$];
    logic              last_q[$];
    int unsigned       errors;

    function new();
      errors = 0;
    endfunction

    function void note_value(logic [VALUE_W-1:0] value);
      logic [VALUE_W-1:0] rem;
      logic [DIGIT_W-1:0] rev[20];
      int                 n;
      rem = value;
      n   = 0;
      do begin
        rev[n] = DIGIT_W'(rem % 10);
        rem    = rem / 10;
        n++;
      end while (rem != 0);
      for (int k = 0; k < n; k++) begin
        char_q.push_back(ASCII_ZERO + CHAR_W'(rev[n-1-k]));
        last_q.push_back(k == n - 1);
      end
    endfunction

    function void check_digit(logic [CHAR_W-1:0] digit_char, logic last_digit);
      logic [CHAR_W-1:0] exp_char;
      logic              exp_last;
      if (char_q.size() == 0) begin
        $error("unexpected result: digit_char %0d last_digit %0b", digit_char, last_digit);
        errors++;
        return;
      end
      exp_char = char_q.pop_front();
      exp_last = last_q.pop_front();
      if (digit_char !== exp_char) begin
        $error("digit_char mismatch: expected %0d actual %0d", exp_char, digit_char);
        errors++;
      end
      if (last_digit !== exp_last) begin
        $error("last_digit mismatch: expected %0b actual %0b", exp_last, last_digit);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return char_q.size();
    endfunction
  endclass

  logic               clk_i   = 1'b0;
  logic               rst_ni  = 1'b0;
  logic               push    = 1'b0;
  logic               full;
  logic [VALUE_W-1:0] value_i = '0;
  logic               empty;
  logic               pop     = 1'b0;
  logic [CHAR_W-1:0]  digit_char_o;
  logic               last_digit_o;

  digit_scoreboard sb = new();
  int unsigned     cycle_count = 0;

  binary_to_decimal_ascii_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .value_i      (value_i),
    .empty        (empty),
    .pop          (pop),
    .digit_char_o (digit_char_o),
    .last_digit_o (last_digit_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // per-item wait, with occasional bursts of back-to-back transfers
  function automatic int unsigned draw_gap(inout int unsigned burst_left);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst_left = $urandom_range(5, 30);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  int unsigned send_burst = 0;
  int unsigned recv_burst = 0;

  task automatic send_value(input logic [VALUE_W-1:0] value);
    int unsigned gap;
    gap = draw_gap(send_burst);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push    <= 1'b1;
    value_i <= value;
    do @(posedge clk_i); while (full);
    sb.note_value(value);
  endtask

  task automatic collect_digits();
    int unsigned gap;
    forever begin
      gap = draw_gap(recv_burst);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      sb.check_digit(digit_char_o, last_digit_o);
    end
  endtask

  function automatic logic [VALUE_W-1:0] random_value();
    longint unsigned lo;
    longint unsigned hi;
    int unsigned     ndig;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6: begin
        // uniform digit count, then a value of that length
        ndig = $urandom_range(1, 10);
        lo   = (ndig == 1) ? 0 : 1;
        for (int i = 1; i < ndig; i++) lo = lo * 10;
        hi = (ndig == 1) ? 9 : lo * 10 - 1;
        if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
        return VALUE_W'(lo + ({$urandom, $urandom} % (hi - lo + 1)));
      end
      7: return $urandom_range(0, 99);
      default: begin
        // straddle a power of ten
        lo = 1;
        for (int i = 0; i < $urandom_range(1, 9); i++) lo = lo * 10;
        return VALUE_W'(lo + $urandom_range(0, 2) - 1);
      end
    endcase
  endfunction

  logic [VALUE_W-1:0] directed_values[] = '{
    32'd0, 32'd1, 32'd9, 32'd10, 32'd11, 32'd99, 32'd100, 32'd101,
    32'd999999999, 32'd1000000000, 32'd1234567890, 32'd123456789,
    32'd2147483647, 32'd2147483648, 32'd3000000000, 32'd4294967289,
    32'd4294967294, 32'd4294967295, 32'h5555_5555, 32'hAAAA_AAAA
  };

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    fork
      collect_digits();
    join_none

    foreach (directed_values[i]) send_value(directed_values[i]);
    for (int i = 0; i < RANDOM_ITEMS; i++) send_value(random_value());
    push <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    // catch any stray transfer after the last expected digit
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/b2da_pkg.sv
hw/rtl/b2da_front.sv
hw/rtl/b2da_fifo.sv
hw/rtl/b2da_back.sv
hw/rtl/binary_to_decimal_ascii_top.sv
hw/rtl/b2da_checker.sv
tb/binary_to_decimal_ascii_top_test.sv
